// ===== hw/rtl/jpq_pkg.sv =====
// Shared constants and controller/datapath interface types for the job queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jpq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam int ID_W   = 16;
    localparam int ARR_W  = 32;
    localparam int SVC_W  = 16;
    localparam int OCC_W  = 5;
    localparam int KEY_W  = 32;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_SERVICE = 1'b1;

    typedef struct packed {
        logic latch;
        logic cmp;
        logic ins;
        logic load_rsp;
        logic load_ent;
        logic rotate;
        logic drop;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic rd_last;
    } t_sts;

endpackage
`default_nettype wire

// ===== hw/rtl/jpq_ctrl.sv =====
// Job queue controller: sequences insert, drop and readout, owns output valid.
// Depends on jpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jpq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic          i_action,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire jpq_pkg::t_sts i_sts,
    output jpq_pkg::t_cmd      o_cmd
);
    import jpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_INS,
        S_RESP,
        S_DROP,
        S_ROT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_free;
    logic   w_accept;
    logic   w_load;

    assign w_free      = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        o_cmd.latch = w_accept;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_action == ACT_INSERT) begin
                        n_state = i_sts.full ? S_DROP : S_CMP;
                    end else begin
                        n_state = i_sts.empty ? S_RESP : S_ROT;
                    end
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_INS;
            end
            S_INS: begin
                o_cmd.ins = 1'b1;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (w_free) begin
                    o_cmd.load_rsp = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DROP: begin
                if (w_free) begin
                    o_cmd.load_rsp = 1'b1;
                    o_cmd.drop     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ROT: begin
                if (w_free) begin
                    o_cmd.load_ent = 1'b1;
                    o_cmd.rotate   = 1'b1;
                    if (i_sts.rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_load = o_cmd.load_rsp || o_cmd.load_ent;

    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/jpq_dp.sv =====
// Job queue datapath: insertion chain of cells, key compare, rotate readout,
// output word register and key mode register. Depends on jpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jpq_dp #(
    parameter int QUEUE_DEPTH = jpq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic                      i_cfg_wr_data,
    input  wire logic [jpq_pkg::ID_W-1:0]  i_job_id,
    input  wire logic [jpq_pkg::ARR_W-1:0] i_arrival_time,
    input  wire logic [jpq_pkg::SVC_W-1:0] i_service_time,
    input  wire jpq_pkg::t_cmd             i_cmd,
    output jpq_pkg::t_sts                  o_sts,
    output logic [jpq_pkg::ID_W-1:0]       o_out_job_id,
    output logic [jpq_pkg::ARR_W-1:0]      o_out_arrival_time,
    output logic [jpq_pkg::SVC_W-1:0]      o_out_service_time,
    output logic                           o_entry_valid,
    output logic                           o_is_last,
    output logic                           o_dropped,
    output logic [jpq_pkg::OCC_W-1:0]      o_occupancy
);
    import jpq_pkg::*;

    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    logic              r_key_mode;
    logic [FW-1:0]     r_fill, n_fill;
    logic [FW-1:0]     r_cnt;
    logic [FW-1:0]     w_last_idx;

    logic [ID_W-1:0]   r_in_id;
    logic [ARR_W-1:0]  r_in_arr;
    logic [SVC_W-1:0]  r_in_svc;
    logic [KEY_W-1:0]  w_new_key;

    logic [ID_W-1:0]   r_id  [QUEUE_DEPTH];
    logic [ARR_W-1:0]  r_arr [QUEUE_DEPTH];
    logic [SVC_W-1:0]  r_svc [QUEUE_DEPTH];
    logic [ID_W-1:0]   n_id  [QUEUE_DEPTH];
    logic [ARR_W-1:0]  n_arr [QUEUE_DEPTH];
    logic [SVC_W-1:0]  n_svc [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] w_gt, r_gt;
    logic [QUEUE_DEPTH-1:0] w_low, w_at, w_after;

    logic [ID_W-1:0]   r_o_id;
    logic [ARR_W-1:0]  r_o_arr;
    logic [SVC_W-1:0]  r_o_svc;
    logic              r_o_valid, r_o_last, r_o_drop;
    logic [OCC_W-1:0]  r_o_occ;

    assign w_last_idx = r_fill - FW'(1);
    assign o_sts.full    = (r_fill == FW'(QUEUE_DEPTH));
    assign o_sts.empty   = (r_fill == '0);
    assign o_sts.rd_last = (r_cnt == w_last_idx);

    assign w_new_key = (r_key_mode == MODE_SERVICE) ?
                       KEY_W'(r_in_svc) : KEY_W'(r_in_arr);

    // mark cells whose key exceeds the new key, plus the tail slot
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_gt[i] = ((FW'(i) < r_fill) &&
                       (((r_key_mode == MODE_SERVICE) ?
                         KEY_W'(r_svc[i]) : KEY_W'(r_arr[i])) > w_new_key)) ||
                      (FW'(i) == r_fill);
        end
    end

    // first marked cell is the insert slot; cells from there on move up
    assign w_low   = r_gt & (~r_gt + QUEUE_DEPTH'(1));
    assign w_at    = ~(w_low - QUEUE_DEPTH'(1));
    assign w_after = {w_at[QUEUE_DEPTH-2:0], 1'b0};

    always_comb begin
        n_id   = r_id;
        n_arr  = r_arr;
        n_svc  = r_svc;
        n_fill = r_fill;
        if (i_cmd.ins) begin
            n_fill = r_fill + FW'(1);
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (w_at[i]) begin
                    n_id[i]  = r_in_id;
                    n_arr[i] = r_in_arr;
                    n_svc[i] = r_in_svc;
                end
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (w_after[i]) begin
                    n_id[i]  = r_id[i-1];
                    n_arr[i] = r_arr[i-1];
                    n_svc[i] = r_svc[i-1];
                end
            end
        end else if (i_cmd.rotate) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                n_id[i]  = r_id[i+1];
                n_arr[i] = r_arr[i+1];
                n_svc[i] = r_svc[i+1];
            end
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (FW'(i) == w_last_idx) begin
                    n_id[i]  = r_id[0];
                    n_arr[i] = r_arr[0];
                    n_svc[i] = r_svc[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_mode <= MODE_ARRIVAL;
            r_fill     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_key_mode <= i_cfg_wr_data;
            end
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_id;
        r_arr <= n_arr;
        r_svc <= n_svc;
        if (i_cmd.latch) begin
            r_in_id  <= i_job_id;
            r_in_arr <= i_arrival_time;
            r_in_svc <= i_service_time;
            r_cnt    <= '0;
        end else if (i_cmd.rotate) begin
            r_cnt <= r_cnt + FW'(1);
        end
        if (i_cmd.cmp) begin
            r_gt <= w_gt;
        end
        if (i_cmd.load_rsp) begin
            r_o_id    <= '0;
            r_o_arr   <= '0;
            r_o_svc   <= '0;
            r_o_valid <= 1'b0;
            r_o_last  <= 1'b1;
            r_o_drop  <= i_cmd.drop;
            r_o_occ   <= OCC_W'(r_fill);
        end else if (i_cmd.load_ent) begin
            r_o_id    <= r_id[0];
            r_o_arr   <= r_arr[0];
            r_o_svc   <= r_svc[0];
            r_o_valid <= 1'b1;
            r_o_last  <= o_sts.rd_last;
            r_o_drop  <= 1'b0;
            r_o_occ   <= OCC_W'(r_fill);
        end
    end

    assign o_out_job_id       = r_o_id;
    assign o_out_arrival_time = r_o_arr;
    assign o_out_service_time = r_o_svc;
    assign o_entry_valid      = r_o_valid;
    assign o_is_last          = r_o_last;
    assign o_dropped          = r_o_drop;
    assign o_occupancy        = r_o_occ;

endmodule
`default_nettype wire

// ===== hw/rtl/job_priority_insertion_queue.sv =====
// Job priority insertion queue top level: controller plus datapath.
// Depends on jpq_pkg, jpq_ctrl and jpq_dp.
`timescale 1ns / 1ps
`default_nettype none
// Holds up to QUEUE_DEPTH jobs sorted by arrival time (key mode 0) or service
// time (key mode 1); equal keys keep insertion order. An insert word goes from
// acceptance to its single result word through capture, a parallel compare of
// every cell against the new key, a shift into the chain and the response load;
// on a full queue it skips compare and shift and loads a drop response. A read
// word streams one result per stored job at one per cycle, while the output is
// not stalled, by rotating the cell chain once around, or one status word when
// empty. Only one word is worked on at a time; the input is stalled until its
// last result is loaded into the output register. Write key mode only while idle.
module job_priority_insertion_queue #(
    parameter int QUEUE_DEPTH = jpq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic                      i_cfg_wr_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_action,
    input  wire logic [jpq_pkg::ID_W-1:0]  i_job_id,
    input  wire logic [jpq_pkg::ARR_W-1:0] i_arrival_time,
    input  wire logic [jpq_pkg::SVC_W-1:0] i_service_time,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [jpq_pkg::ID_W-1:0]       o_out_job_id,
    output logic [jpq_pkg::ARR_W-1:0]      o_out_arrival_time,
    output logic [jpq_pkg::SVC_W-1:0]      o_out_service_time,
    output logic                           o_entry_valid,
    output logic                           o_is_last,
    output logic                           o_dropped,
    output logic [jpq_pkg::OCC_W-1:0]      o_occupancy
);
    import jpq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    jpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    jpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_job_id           (i_job_id),
        .i_arrival_time     (i_arrival_time),
        .i_service_time     (i_service_time),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .o_out_job_id       (o_out_job_id),
        .o_out_arrival_time (o_out_arrival_time),
        .o_out_service_time (o_out_service_time),
        .o_entry_valid      (o_entry_valid),
        .o_is_last          (o_is_last),
        .o_dropped          (o_dropped),
        .o_occupancy        (o_occupancy)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/jpq_checker.sv =====
// Port-level checks for the job queue, bound to the top level.
// Depends on jpq_pkg and job_priority_insertion_queue.
`timescale 1ns / 1ps
`default_nettype none
module jpq_checker #(
    parameter int QUEUE_DEPTH = jpq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire logic                      o_entry_valid,
    input wire logic                      o_is_last,
    input wire logic                      o_dropped,
    input wire logic [jpq_pkg::OCC_W-1:0] o_occupancy
);
    import jpq_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word lost while stalled");

    a_drop_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dropped |-> !o_entry_valid && o_is_last)
        else $error("drop word carries an entry or is not last");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dropped |-> o_occupancy == OCC_W'(QUEUE_DEPTH))
        else $error("drop reported while queue not full");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_entry_valid |-> o_is_last)
        else $error("status word not marked last");

endmodule

bind job_priority_insertion_queue jpq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_jpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_entry_valid (o_entry_valid),
    .o_is_last     (o_is_last),
    .o_dropped     (o_dropped),
    .o_occupancy   (o_occupancy)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for job_priority_insertion_queue: sorted inserts, full-queue drops
// and in-order readouts under both key modes and four idle/stall phases.
// Depends on jpq_pkg and the job_priority_insertion_queue RTL.
`timescale 1ns / 1ps
module tb;
    import jpq_pkg::*;

    localparam int DEPTH = DEFAULT_QUEUE_DEPTH;

    typedef struct packed {
        logic             action;
        logic [ID_W-1:0]  job_id;
        logic [ARR_W-1:0] arrival;
        logic [SVC_W-1:0] service;
    } job_word_t;

    typedef struct packed {
        logic [ID_W-1:0]  job_id;
        logic [ARR_W-1:0] arrival;
        logic [SVC_W-1:0] service;
        logic             entry_valid;
        logic             is_last;
        logic             dropped;
        logic [OCC_W-1:0] occupancy;
    } job_listing_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic             i_cfg_wr_data = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             i_action = 1'b0;
    logic [ID_W-1:0]  i_job_id = '0;
    logic [ARR_W-1:0] i_arrival_time = '0;
    logic [SVC_W-1:0] i_service_time = '0;
    logic             i_out_stall = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [ID_W-1:0]  o_out_job_id;
    logic [ARR_W-1:0] o_out_arrival_time;
    logic [SVC_W-1:0] o_out_service_time;
    logic             o_entry_valid;
    logic             o_is_last;
    logic             o_dropped;
    logic [OCC_W-1:0] o_occupancy;

    job_word_t    word_q[$];
    job_listing_t listing_q[$];
    job_word_t    next_word;
    job_listing_t got;
    job_listing_t want;

    logic             sort_mode = MODE_ARRIVAL;
    logic [ID_W-1:0]  slot_id [DEPTH];
    logic [ARR_W-1:0] slot_arr [DEPTH];
    logic [SVC_W-1:0] slot_svc [DEPTH];
    int               held = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;

    always #4 i_clk = ~i_clk;

    job_priority_insertion_queue u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_job_id           (i_job_id),
        .i_arrival_time     (i_arrival_time),
        .i_service_time     (i_service_time),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_job_id       (o_out_job_id),
        .o_out_arrival_time (o_out_arrival_time),
        .o_out_service_time (o_out_service_time),
        .o_entry_valid      (o_entry_valid),
        .o_is_last          (o_is_last),
        .o_dropped          (o_dropped),
        .o_occupancy        (o_occupancy)
    );

    function automatic logic [KEY_W-1:0] sort_key(input logic mode, input logic [ARR_W-1:0] arr,
                                                  input logic [SVC_W-1:0] svc);
        return (mode == MODE_SERVICE) ? KEY_W'(svc) : KEY_W'(arr);
    endfunction

    // Apply one accepted word to the job list and queue the listings it produces.
    task automatic sort_and_list(input job_word_t w);
        job_listing_t     r;
        int               pos;
        logic [KEY_W-1:0] new_key;
        r = '0;
        if (w.action == ACT_INSERT) begin
            r.is_last = 1'b1;
            if (held >= DEPTH) begin
                r.dropped = 1'b1;
            end else begin
                new_key = sort_key(sort_mode, w.arrival, w.service);
                pos = 0;
                while (pos < held && sort_key(sort_mode, slot_arr[pos], slot_svc[pos]) <= new_key)
                    pos++;
                for (int i = held; i > pos; i--) begin
                    slot_id[i]  = slot_id[i-1];
                    slot_arr[i] = slot_arr[i-1];
                    slot_svc[i] = slot_svc[i-1];
                end
                slot_id[pos]  = w.job_id;
                slot_arr[pos] = w.arrival;
                slot_svc[pos] = w.service;
                held++;
            end
            r.occupancy = OCC_W'(held);
            listing_q.push_back(r);
        end else if (held == 0) begin
            r.is_last = 1'b1;
            listing_q.push_back(r);
        end else begin
            for (int i = 0; i < held; i++) begin
                r.job_id      = slot_id[i];
                r.arrival     = slot_arr[i];
                r.service     = slot_svc[i];
                r.entry_valid = 1'b1;
                r.is_last     = (i == held - 1);
                r.occupancy   = OCC_W'(held);
                listing_q.push_back(r);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                sort_and_list('{i_action, i_job_id, i_arrival_time, i_service_time});
            if (!i_in_valid || !o_in_stall) begin
                if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = word_q.pop_front();
                    i_in_valid     <= 1'b1;
                    i_action       <= next_word.action;
                    i_job_id       <= next_word.job_id;
                    i_arrival_time <= next_word.arrival;
                    i_service_time <= next_word.service;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_out_job_id, o_out_arrival_time, o_out_service_time, o_entry_valid,
                        o_is_last, o_dropped, o_occupancy};
                if (listing_q.size() == 0) begin
                    $error("result word with nothing expected: id %0h occupancy %0d",
                           got.job_id, got.occupancy);
                    fail_count++;
                end else begin
                    want = listing_q.pop_front();
                    if (got.job_id !== want.job_id) begin
                        $error("out_job_id: expected %0h, got %0h", want.job_id, got.job_id);
                        fail_count++;
                    end
                    if (got.arrival !== want.arrival) begin
                        $error("out_arrival_time: expected %0h, got %0h",
                               want.arrival, got.arrival);
                        fail_count++;
                    end
                    if (got.service !== want.service) begin
                        $error("out_service_time: expected %0h, got %0h",
                               want.service, got.service);
                        fail_count++;
                    end
                    if (got.entry_valid !== want.entry_valid) begin
                        $error("entry_valid: expected %0b, got %0b",
                               want.entry_valid, got.entry_valid);
                        fail_count++;
                    end
                    if (got.is_last !== want.is_last) begin
                        $error("is_last: expected %0b, got %0b", want.is_last, got.is_last);
                        fail_count++;
                    end
                    if (got.dropped !== want.dropped) begin
                        $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
                        fail_count++;
                    end
                    if (got.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, got.occupancy);
                        fail_count++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic push_word(input logic act, input logic [ID_W-1:0] id,
                             input logic [ARR_W-1:0] arr, input logic [SVC_W-1:0] svc);
        word_q.push_back('{act, id, arr, svc});
    endtask

    // Keys cluster on small values and the top of the range so ties are common.
    function automatic job_word_t random_word();
        job_word_t w;
        w.action = ($urandom_range(99) < 35) ? ACT_READ : ACT_INSERT;
        w.job_id = ID_W'($urandom);
        case ($urandom_range(2))
            0: w.arrival = ARR_W'($urandom_range(7));
            1: w.arrival = ARR_W'($urandom);
            default: w.arrival = $urandom_range(1) ? '1 : ARR_W'(32'hFFFF_FFFE);
        endcase
        case ($urandom_range(2))
            0: w.service = SVC_W'($urandom_range(7));
            1: w.service = SVC_W'($urandom);
            default: w.service = $urandom_range(1) ? '1 : SVC_W'(16'hFFFE);
        endcase
        return w;
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (word_q.size() != 0 || i_in_valid || listing_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_key_mode(input logic mode);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sort_mode = mode;
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) word_q.push_back(random_word());
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_key_mode(MODE_ARRIVAL);

        // arrival order: empty read, head, tail, tie behind an equal key
        push_word(ACT_READ,   16'h0000, 32'h0000_0000, 16'h0000);
        push_word(ACT_INSERT, 16'h0001, 32'd100,       16'h0050);
        push_word(ACT_INSERT, 16'h0000, 32'h0000_0000, 16'hFFFF);
        push_word(ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000);
        push_word(ACT_INSERT, 16'h00AA, 32'd100,       16'h0007);
        push_word(ACT_READ,   16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        wait_drained();

        // switch to service order with jobs already stored
        write_key_mode(MODE_SERVICE);
        push_word(ACT_INSERT, 16'h1234, 32'h8000_0000, 16'h0000);
        push_word(ACT_INSERT, 16'h5678, 32'd7,         16'hFFFF);
        push_word(ACT_INSERT, 16'h9ABC, 32'd7,         16'h0007);
        push_word(ACT_READ,   16'h0000, 32'h0000_0000, 16'h0000);
        wait_drained();

        run_random(120, 0, 0);
        write_key_mode(MODE_ARRIVAL);
        run_random(120, 67, 0);
        write_key_mode(MODE_SERVICE);
        run_random(120, 0, 67);
        write_key_mode(MODE_ARRIVAL);
        run_random(120, 21, 21);

        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("job_priority_insertion_queue regression: pass");
        else
            $display("job_priority_insertion_queue regression: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("job_priority_insertion_queue regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/jpq_pkg.sv
hw/rtl/jpq_ctrl.sv
hw/rtl/jpq_dp.sv
hw/rtl/job_priority_insertion_queue.sv
hw/rtl/jpq_checker.sv
tb/tb.sv
